>>> hw/rtl/fstg_pkg.sv
// ----------------------------------------------------------------------------
// Floor span texel generator package
// Shared widths, codes and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package fstg_pkg;

  // Field widths of the pixel and result channels.
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned TEXEL_W  = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Fixed-point widths.
  localparam int unsigned POS_W  = 32;  // Q16.16 position and step
  localparam int unsigned VEC_W  = 16;  // Q2.14 direction and plane
  localparam int unsigned DIST_W = 26;  // unsigned Q10.16 row distance
  localparam int unsigned PROD_W = 44;  // signed distance times ray term
  localparam int unsigned DVD_W  = 28;  // divider dividend and quotient
  localparam int unsigned DVS_W  = 11;  // divider divisor

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POSE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_Y = 3'd5;

  // Operand choice for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_LEFT_X,
    MUL_LEFT_Y,
    MUL_SPAN_X,
    MUL_SPAN_Y
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     dist_load;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     recip_load;
    logic     world_x_set;
    logic     world_y_set;
    logic     step_x_set;
    logic     step_y_set;
    logic     emit;
    logic     emit_from_in;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
    logic in_below;
    logic in_col_zero;
  } ctrl_stat_t;

endpackage

>>> hw/rtl/fstg_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fstg_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fstg_pkg::DVD_W-1:0]  dividend,
  input  logic [fstg_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [fstg_pkg::DVD_W-1:0]  quotient
);
  import fstg_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = !diff[DVS_W+1];
  end

  // Control: a run counts down through the quotient bits and raises done when the count runs out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Working registers; the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/fstg_datapath.sv
// ----------------------------------------------------------------------------
// Floor span datapath
// Camera registers, row setup arithmetic, world position and step state,
// texel lookup and the result register.
// ----------------------------------------------------------------------------
module fstg_datapath #(
  parameter int unsigned SCREEN_WIDTH   = 640,
  parameter int unsigned SCREEN_HEIGHT  = 480,
  parameter int unsigned TEXTURE_WIDTH  = 64,
  parameter int unsigned TEXTURE_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fstg_pkg::ctrl_cmd_t               cmd,
  output fstg_pkg::ctrl_stat_t              stat,
  input  logic [fstg_pkg::COORD_W-1:0]      in_row,
  input  logic [fstg_pkg::COORD_W-1:0]      in_col,
  input  logic                              cfg_we,
  input  logic [fstg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fstg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fstg_pkg::TEXEL_W-1:0]      out_texel_u,
  output logic [fstg_pkg::TEXEL_W-1:0]      out_texel_v,
  output logic [fstg_pkg::COORD_W-1:0]      out_row,
  output logic [fstg_pkg::COORD_W-1:0]      out_col,
  output logic                              out_valid_res
);
  import fstg_pkg::*;

  localparam logic [COORD_W-1:0] HALF    = COORD_W'(SCREEN_HEIGHT / 2);
  localparam logic [6:0]         TEX_W   = 7'(TEXTURE_WIDTH);
  localparam logic [6:0]         TEX_H   = 7'(TEXTURE_HEIGHT);

  // Reciprocal of the screen width, rounded up, so that one multiply and a
  // shift give the exact truncated quotient for every dividend below 2^DVD_W.
  localparam int unsigned RCP_SH  = DVD_W + $clog2(SCREEN_WIDTH);
  localparam int unsigned RCP_W   = DVD_W + 1;
  localparam int unsigned RPROD_W = DVD_W + RCP_W;
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << RCP_SH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_FULL);

  // Texel index from the fraction bits of a position.
  function automatic logic [TEXEL_W-1:0] texel_of(input logic [15:0] frac,
                                                  input logic [6:0]  size);
    logic [22:0] scaled;
    logic [6:0]  idx;
    scaled = {7'd0, frac} * {16'd0, size};
    idx    = scaled[22:16] & (size - 7'd1);
    return idx[TEXEL_W-1:0];
  endfunction

  // Camera configuration registers.
  logic [POS_W-1:0] pose_x_r, pose_y_r;
  logic [VEC_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r  <= '0;
      pose_y_r  <= '0;
      dir_x_r   <= 16'd16384;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= 16'd10813;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSE_X:      pose_x_r  <= cfg_data;
        REG_POSE_Y:      pose_y_r  <= cfg_data;
        REG_VIEW_DIR_X:  dir_x_r   <= cfg_data[VEC_W-1:0];
        REG_VIEW_DIR_Y:  dir_y_r   <= cfg_data[VEC_W-1:0];
        REG_CAM_PLANE_X: plane_x_r <= cfg_data[VEC_W-1:0];
        REG_CAM_PLANE_Y: plane_y_r <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured pixel of a row start.
  logic [COORD_W-1:0] row_r, col_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  // Ray terms: leftmost ray and the full left-to-right span (twice the plane).
  logic signed [VEC_W:0] left_x, left_y, span_x, span_y;

  always_comb begin
    left_x = $signed({dir_x_r[VEC_W-1], dir_x_r}) - $signed({plane_x_r[VEC_W-1], plane_x_r});
    left_y = $signed({dir_y_r[VEC_W-1], dir_y_r}) - $signed({plane_y_r[VEC_W-1], plane_y_r});
    span_x = $signed({plane_x_r, 1'b0});
    span_y = $signed({plane_y_r, 1'b0});
  end

  // Shared multiplier: row distance times one ray term, registered.
  logic [DIST_W-1:0]        dist_r;
  logic signed [VEC_W:0]    mul_b;
  logic signed [DIST_W:0]   mul_a;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    mul_a = $signed({1'b0, dist_r});
    case (cmd.mul_sel)
      MUL_LEFT_X: mul_b = left_x;
      MUL_LEFT_Y: mul_b = left_y;
      MUL_SPAN_X: mul_b = span_x;
      MUL_SPAN_Y: mul_b = span_y;
      default:    mul_b = left_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Magnitude of the product scaled down by 2^14, truncated toward zero.
  logic [PROD_W-1:0] prod_mag;
  logic [DVD_W-1:0]  prod_scaled;
  logic              prod_neg;
  logic [POS_W-1:0]  offset;

  always_comb begin
    prod_neg    = prod_r[PROD_W-1];
    prod_mag    = prod_neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    prod_scaled = prod_mag[DVD_W+13:14];
    offset      = prod_neg ? (POS_W'(0) - POS_W'(prod_scaled)) : POS_W'(prod_scaled);
  end

  // Serial divider for the row distance.
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quotient;
  logic             div_done;
  logic [COORD_W-1:0] horizon_dist;

  always_comb begin
    horizon_dist = in_row - HALF;
    div_dividend = {2'b00, HALF, 16'd0};
    div_divisor  = {1'b0, horizon_dist};
  end

  fstg_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.dist_load) begin
      dist_r <= div_quotient[DIST_W-1:0];
    end
  end

  // Step magnitude: scaled product divided by the screen width through the
  // reciprocal multiply, registered.
  logic [RPROD_W-1:0] step_prod_r;
  logic [DVD_W-1:0]   step_quo;

  always_ff @(posedge clk) begin
    if (cmd.recip_load) begin
      step_prod_r <= RPROD_W'(prod_scaled) * RPROD_W'(RCP_M);
    end
  end

  assign step_quo = DVD_W'(step_prod_r >> RCP_SH);

  // Step with the sign of the product restored.
  logic [POS_W-1:0] step_val;

  assign step_val = prod_neg ? (POS_W'(0) - POS_W'(step_quo)) : POS_W'(step_quo);

  // Source pixel of a result: straight from the input or from the capture.
  logic [COORD_W-1:0] src_row, src_col;
  logic               src_below;

  always_comb begin
    src_row   = cmd.emit_from_in ? in_row : row_r;
    src_col   = cmd.emit_from_in ? in_col : col_r;
    src_below = src_row > HALF;
  end

  // World position and step state.
  logic [POS_W-1:0] world_x_r, world_y_r, step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_x_r <= '0;
      world_y_r <= '0;
      step_x_r  <= '0;
      step_y_r  <= '0;
    end else begin
      if (cmd.world_x_set) begin
        world_x_r <= pose_x_r + offset;
      end
      if (cmd.world_y_set) begin
        world_y_r <= pose_y_r + offset;
      end
      if (cmd.step_x_set) begin
        step_x_r <= step_val;
      end
      if (cmd.step_y_set) begin
        step_y_r <= step_val;
      end
      if (cmd.emit && src_below) begin
        world_x_r <= world_x_r + step_x_r;
        world_y_r <= world_y_r + step_y_r;
      end
    end
  end

  // Result register: holds one result until the receiver takes it.
  logic                 out_valid_r;
  logic [TEXEL_W-1:0]   texel_u_r, texel_v_r;
  logic [COORD_W-1:0]   res_row_r, res_col_r;
  logic                 valid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      texel_u_r   <= src_below ? texel_of(world_x_r[15:0], TEX_W) : '0;
      texel_v_r   <= src_below ? texel_of(world_y_r[15:0], TEX_H) : '0;
      res_row_r   <= src_row;
      res_col_r   <= src_col;
      valid_res_r <= src_below;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_texel_u   = texel_u_r;
  assign out_texel_v   = texel_v_r;
  assign out_row       = res_row_r;
  assign out_col       = res_col_r;
  assign out_valid_res = valid_res_r;

  // Status back to the controller.
  always_comb begin
    stat.div_done    = div_done;
    stat.out_free    = !out_valid_r || !out_stall;
    stat.in_below    = in_row > HALF;
    stat.in_col_zero = (in_col == '0);
  end

endmodule

>>> hw/rtl/fstg_ctrl.sv
// ----------------------------------------------------------------------------
// Floor span controller
// Accepts pixels and sequences the row setup through the shared multiplier
// and divider of the datapath.
// ----------------------------------------------------------------------------
module fstg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fstg_pkg::ctrl_stat_t stat,
  output fstg_pkg::ctrl_cmd_t  cmd
);
  import fstg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST_RUN,
    S_MUL_LX,
    S_SET_WX,
    S_SET_WY,
    S_SX_MUL,
    S_SX_SET,
    S_SY_MUL,
    S_SY_SET,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Pixels are taken only from idle and only with room in the result register.
  assign in_stall = !((state_r == S_IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_LEFT_X;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.in_below && stat.in_col_zero) begin
            cmd.capture   = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt     = S_DIST_RUN;
          end else begin
            cmd.emit         = 1'b1;
            cmd.emit_from_in = 1'b1;
          end
        end
      end
      S_DIST_RUN: begin
        if (stat.div_done) begin
          cmd.dist_load = 1'b1;
          state_nxt     = S_MUL_LX;
        end
      end
      S_MUL_LX: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_LEFT_X;
        state_nxt    = S_SET_WX;
      end
      S_SET_WX: begin
        cmd.world_x_set = 1'b1;
        cmd.mul_load    = 1'b1;
        cmd.mul_sel     = MUL_LEFT_Y;
        state_nxt       = S_SET_WY;
      end
      S_SET_WY: begin
        cmd.world_y_set = 1'b1;
        cmd.mul_load    = 1'b1;
        cmd.mul_sel     = MUL_SPAN_X;
        state_nxt       = S_SX_MUL;
      end
      S_SX_MUL: begin
        cmd.recip_load = 1'b1;
        state_nxt      = S_SX_SET;
      end
      S_SX_SET: begin
        cmd.step_x_set = 1'b1;
        cmd.mul_load   = 1'b1;
        cmd.mul_sel    = MUL_SPAN_Y;
        state_nxt      = S_SY_MUL;
      end
      S_SY_MUL: begin
        cmd.recip_load = 1'b1;
        state_nxt      = S_SY_SET;
      end
      S_SY_SET: begin
        cmd.step_y_set = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/floor_span_texel_generator_core.sv
// ----------------------------------------------------------------------------
// Floor span texel generator
// Raycaster floor casting: maps screen pixels in raster order to floor
// texture coordinates from the camera pose.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels (in_row, in_col) enter on the in_ channel; a transfer happens when
//   in_valid is high and in_stall is low. Each pixel gives exactly one result
//   on the out_ channel, transferred when out_valid is high and out_stall low.
//   Camera pose, direction and plane are written on the cfg_ port (cfg_ready
//   is always high) while no pixel is in flight.
//   A pixel that is not the first of a span below the horizon is registered
//   into the result stage in the cycle after its transfer, and one such pixel
//   can be taken every cycle while the receiver does not stall.
//   A column-zero pixel below the horizon runs the row setup: a serial
//   division for the row distance at one quotient bit per cycle, then
//   multiplier and reciprocal-multiply cycles for the start position and
//   the steps. Its result is registered once the result register is free,
//   and in_stall stays high until the controller is back in idle.
//   Reset clears the world position and step to zero and loads the default
//   camera. While the receiver stalls, the held result stays put and a new
//   pixel is not taken until the result register can be refilled.
// ----------------------------------------------------------------------------
module floor_span_texel_generator_core #(
  parameter int unsigned SCREEN_WIDTH   = 640,
  parameter int unsigned SCREEN_HEIGHT  = 480,
  parameter int unsigned TEXTURE_WIDTH  = 64,
  parameter int unsigned TEXTURE_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fstg_pkg::COORD_W-1:0]      in_row,
  input  logic [fstg_pkg::COORD_W-1:0]      in_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fstg_pkg::TEXEL_W-1:0]      out_texel_u,
  output logic [fstg_pkg::TEXEL_W-1:0]      out_texel_v,
  output logic [fstg_pkg::COORD_W-1:0]      out_row,
  output logic [fstg_pkg::COORD_W-1:0]      out_col,
  output logic                              out_valid_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fstg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fstg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fstg_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       cfg_we;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  fstg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fstg_datapath #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .TEXTURE_WIDTH  (TEXTURE_WIDTH),
    .TEXTURE_HEIGHT (TEXTURE_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_row        (in_row),
    .in_col        (in_col),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_texel_u   (out_texel_u),
    .out_texel_v   (out_texel_v),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_valid_res (out_valid_res)
  );

endmodule

>>> sim/floor_span_texel_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor span texel generator testbench
// Streams raster pixels into the core under several camera settings and
// checks every result against a fixed-point floor-casting predictor kept in
// step with each input transfer. Both channels idle at random, the receiver
// holds off once for a long stretch, and the camera is reprogrammed between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module floor_span_texel_generator_core_tb;
  import fstg_pkg::*;

  localparam int unsigned SCR_W  = 640;
  localparam int unsigned SCR_H  = 480;
  localparam int unsigned TEX_W  = 64;
  localparam int unsigned TEX_H  = 64;
  localparam int          HALF_H = SCR_H / 2;
  localparam longint      STEP_DIV = longint'(SCR_W) * 16384;

  // Indexes past the last camera register; the core must ignore them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 290;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE_CYC   = 4;
  localparam int TAIL_CYC     = 120;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pixel_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] u;
    logic [TEXEL_W-1:0] v;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               below;
  } texel_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_row = '0;
  logic [COORD_W-1:0]    in_col = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TEXEL_W-1:0]    out_texel_u;
  logic [TEXEL_W-1:0]    out_texel_v;
  logic [COORD_W-1:0]    out_row;
  logic [COORD_W-1:0]    out_col;
  logic                  out_valid_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Camera registers as the core should hold them.
  logic [31:0]        cam_pose_x = '0;
  logic [31:0]        cam_pose_y = '0;
  logic signed [15:0] cam_dir_x = 16'sd16384;
  logic signed [15:0] cam_dir_y = '0;
  logic signed [15:0] cam_plane_x = '0;
  logic signed [15:0] cam_plane_y = 16'sd10813;

  // Span walker state: world position and per-pixel step, Q16.16.
  logic [31:0] span_pos_x = '0;
  logic [31:0] span_pos_y = '0;
  logic [31:0] span_step_x = '0;
  logic [31:0] span_step_y = '0;

  pixel_t     pixel_q[$];
  texel_rec_t texel_q[$];

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 64;
  int          hold_ticket = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  floor_span_texel_generator_core #(
    .SCREEN_WIDTH  (SCR_W),
    .SCREEN_HEIGHT (SCR_H),
    .TEXTURE_WIDTH (TEX_W),
    .TEXTURE_HEIGHT(TEX_H)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row       (in_row),
    .in_col       (in_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_texel_u  (out_texel_u),
    .out_texel_v  (out_texel_v),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_valid_res(out_valid_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Texture coordinate from the fraction bits of a world position.
  function automatic logic [TEXEL_W-1:0] texel_of(input logic [31:0] pos,
                                                   input int unsigned size);
    logic [31:0] scaled;
    scaled = 32'(pos[15:0]) * size;
    return TEXEL_W'((scaled >> 16) & (size - 1));
  endfunction

  // Advance the span walker by one accepted pixel and queue its texel.
  task automatic predict_texel(input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col);
    longint     lx, ly, rx, ry, row_dist, stp_x, stp_y, off_x, off_y;
    texel_rec_t rec;
    rec.row   = row;
    rec.col   = col;
    rec.below = (int'(row) > HALF_H);
    rec.u     = '0;
    rec.v     = '0;
    if (rec.below) begin
      // Column zero starts a span: row distance, step and start position.
      if (col == 0) begin
        lx       = longint'(cam_dir_x) - longint'(cam_plane_x);
        ly       = longint'(cam_dir_y) - longint'(cam_plane_y);
        rx       = longint'(cam_dir_x) + longint'(cam_plane_x);
        ry       = longint'(cam_dir_y) + longint'(cam_plane_y);
        row_dist = (longint'(HALF_H) * 65536) / longint'(int'(row) - HALF_H);
        stp_x    = (row_dist * (rx - lx)) / STEP_DIV;
        stp_y    = (row_dist * (ry - ly)) / STEP_DIV;
        off_x    = (row_dist * lx) / 16384;
        off_y    = (row_dist * ly) / 16384;
        span_step_x = 32'(stp_x);
        span_step_y = 32'(stp_y);
        span_pos_x  = cam_pose_x + 32'(off_x);
        span_pos_y  = cam_pose_y + 32'(off_y);
      end
      rec.u = texel_of(span_pos_x, TEX_W);
      rec.v = texel_of(span_pos_y, TEX_H);
      span_pos_x = span_pos_x + span_step_x;
      span_pos_y = span_pos_y + span_step_y;
    end
    texel_q.push_back(rec);
  endtask

  // Mirror of a configuration write; unknown indexes change nothing.
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_POSE_X:      cam_pose_x  = data;
      REG_POSE_Y:      cam_pose_y  = data;
      REG_VIEW_DIR_X:  cam_dir_x   = data[15:0];
      REG_VIEW_DIR_Y:  cam_dir_y   = data[15:0];
      REG_CAM_PLANE_X: cam_plane_x = data[15:0];
      REG_CAM_PLANE_Y: cam_plane_y = data[15:0];
      default: ;
    endcase
  endtask

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Program a camera setting picked by phase; the upper bits of the
  // 16-bit registers carry junk that the core must drop.
  task automatic program_camera(input int phase);
    logic [31:0] px, py;
    logic [15:0] dx, dy, cx, cy;
    px = $urandom;
    py = $urandom;
    dx = 16'($urandom);
    dy = 16'($urandom);
    cx = 16'($urandom);
    cy = 16'($urandom);
    case (phase)
      2: begin
        px = 32'h7FFF_FFFF; py = 32'h7FFF_FFFF;
        dx = 16'h7FFF; dy = 16'h7FFF; cx = 16'h7FFF; cy = 16'h7FFF;
      end
      3: begin
        px = 32'h8000_0000; py = 32'h8000_0000;
        dx = 16'h8000; dy = 16'h8000; cx = 16'h8000; cy = 16'h8000;
      end
      6: begin
        px = '0; py = 32'hFFFF_FFFF;
        dx = 16'h8000; dy = '0; cx = 16'h7FFF; cy = 16'h8000;
      end
      default: ;
    endcase
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_POSE_X, px);
    write_reg(REG_POSE_Y, py);
    write_reg(REG_VIEW_DIR_X, {16'($urandom), dx});
    write_reg(REG_VIEW_DIR_Y, {16'($urandom), dy});
    write_reg(REG_CAM_PLANE_X, {16'($urandom), cx});
    write_reg(REG_CAM_PLANE_Y, {16'($urandom), cy});
    write_reg(REG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pixel(input int row, input int col);
    pixel_q.push_back('{row: COORD_W'(row), col: COORD_W'(col)});
  endtask

  // Edges of the screen, the horizon and the reset state.
  task automatic queue_directed();
    push_pixel(300, 5);     // span with no column zero, reset state
    push_pixel(0, 0);
    push_pixel(HALF_H, 0);  // horizon row itself
    push_pixel(HALF_H, 3);
    push_pixel(HALF_H + 1, 0);
    push_pixel(HALF_H + 1, 1);
    push_pixel(HALF_H + 1, 2);
    push_pixel(HALF_H - 1, 0);
    push_pixel(HALF_H + 1, 3); // pixel above the horizon in between left state alone
    push_pixel(SCR_H - 1, 0);
    push_pixel(SCR_H - 1, SCR_W - 1);
    push_pixel(SCR_H - 1, SCR_W);
    push_pixel(SCR_H, 0);   // rows past the screen still cast
    push_pixel(SCR_H, 1);
    push_pixel(1023, 0);
    push_pixel(1023, 1023);
    push_pixel(1023, 512);
    push_pixel(0, 1023);
    push_pixel(360, 0);
    push_pixel(360, 682);
    push_pixel(512, 341);
  endtask

  // Mostly whole spans from column zero, plus spans picked up mid-row,
  // horizon rows and single random pixels.
  task automatic queue_random_traffic(input int n_items);
    int added, kind, len, r, c0;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(99);
      len  = $urandom_range(24, 1);
      c0   = 0;
      if (kind < 60) begin
        r = $urandom_range(SCR_H - 1, HALF_H + 1);
      end else if (kind < 70) begin
        r = $urandom_range(1023, SCR_H);
      end else if (kind < 78) begin
        r   = $urandom_range(HALF_H, 0);
        len = $urandom_range(12, 1);
      end else if (kind < 88) begin
        r  = $urandom_range(1023, 0);
        c0 = $urandom_range(1023 - len, 1);
      end else begin
        r   = $urandom_range(1023, 0);
        c0  = $urandom_range(1023, 0);
        len = 1;
      end
      for (int i = 0; i < len; i++) begin
        push_pixel(r, c0 + i);
      end
      added += len;
    end
  endtask

  // Wait until every pixel is sent and every texel has come back.
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || texel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  task automatic check_texel();
    texel_rec_t rec;
    if (texel_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual row %0d col %0d",
               $time, out_row, out_col);
      error_count++;
    end else begin
      rec = texel_q.pop_front();
      compare_field("texel_u", rec.u, out_texel_u);
      compare_field("texel_v", rec.v, out_texel_v);
      compare_field("row", rec.row, out_row);
      compare_field("col", rec.col, out_col);
      compare_field("valid_res", rec.below, out_valid_res);
    end
  endtask

  // Pixel driver: a new pixel is offered only once the current one has
  // transferred; each transfer is fed to the predictor.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_texel(in_row, in_col);
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_row   <= pixel_q[0].row;
          in_col   <= pixel_q[0].col;
          void'(pixel_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and the occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_texel();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_served != hold_ticket) begin
        hold_served = hold_ticket;
        hold_left   = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("floor_span_texel_generator_core_tb: FAIL");
      $finish;
    end
  end

  // Sequence: reset, directed pixels on the reset camera, then random
  // phases under changing camera settings and idle patterns.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    queue_directed();
    drain();
    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      if (phase <= 2) begin
        send_idle_pct <= 38;
        recv_idle_pct <= 64;
      end else if (phase <= 4) begin
        send_idle_pct <= 64;
        recv_idle_pct <= 38;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      program_camera(phase);
      queue_random_traffic(PHASE_ITEMS);
      // Back up the core while the sender keeps offering pixels.
      if (phase == 5) begin
        hold_ticket <= hold_ticket + 1;
      end
      drain();
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (texel_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, texel_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("floor_span_texel_generator_core_tb: PASS");
    end else begin
      $display("floor_span_texel_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
